@@ sv/stfs_pkg.sv @@
`default_nettype none

package stfs_pkg;

    // Sizing of the block
    localparam int NUM_CORES        = 64;
    localparam int COUNTER_BITS     = 64;
    localparam int THRESH_FRAC_BITS = 16;

    // Fixed field widths
    localparam int CORE_W     = 6;
    localparam int CNT_IN_W   = 64;
    localparam int THR_W      = 17;
    localparam int FREQ_W     = 16;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Derived widths
    localparam int CORE_AW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int LO_W     = COUNTER_BITS / 2;
    localparam int HI_W     = COUNTER_BITS - LO_W;
    localparam int PLO_W    = LO_W + THR_W;
    localparam int PHI_W    = HI_W + THR_W;
    localparam int PROD_W   = COUNTER_BITS + THRESH_FRAC_BITS + 1;
    localparam int PAIR_W   = 2 * COUNTER_BITS;

    typedef logic [CORE_W-1:0]       t_core;
    typedef logic [CORE_AW-1:0]      t_core_addr;
    typedef logic [CNT_IN_W-1:0]     t_cnt_in;
    typedef logic [COUNTER_BITS-1:0] t_cnt;
    typedef logic [THR_W-1:0]        t_thr;
    typedef logic [FREQ_W-1:0]       t_freq;
    typedef logic [TOTAL_W-1:0]      t_total;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]   t_cfg_data;
    typedef logic [PLO_W-1:0]        t_plo;
    typedef logic [PHI_W-1:0]        t_phi;
    typedef logic [PROD_W-1:0]       t_prod;

    // Configuration register indexes
    localparam t_cfg_idx CFG_THRESHOLD_LOW   = 3'd0;
    localparam t_cfg_idx CFG_THRESHOLD_HIGH  = 3'd1;
    localparam t_cfg_idx CFG_FREQ_BELOW_LOW  = 3'd2;
    localparam t_cfg_idx CFG_FREQ_BELOW_HIGH = 3'd3;
    localparam t_cfg_idx CFG_FREQ_ABOVE_HIGH = 3'd4;

    // Configuration reset values
    localparam t_thr  RST_THRESHOLD_LOW   = 17'd32768;
    localparam t_thr  RST_THRESHOLD_HIGH  = 17'd45875;
    localparam t_freq RST_FREQ_BELOW_LOW  = 16'd1000;
    localparam t_freq RST_FREQ_BELOW_HIGH = 16'd1000;
    localparam t_freq RST_FREQ_ABOVE_HIGH = 16'd3000;

endpackage

`default_nettype wire

@@ sv/scalability_threshold_freq_select_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  -----------------------------------------
// in        sink       i_in_valid / o_in_ready    i_core_index, i_productive_count,
//                                                 i_active_count
// out       source     o_out_valid / i_out_ready  o_out_core, o_freq_request,
//                                                 o_write_needed, o_request_total
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction per cycle while the output is not stalled; a result passes through the
// five-stage pipe (counter RAM read, delta, partial products, product sum, threshold
// compare and last-setting check) and leaves from the output register.
// Reset is synchronous: it clears stage valids, the per-core seen and setting-valid bits,
// the change count and restores configuration defaults. No clearing pass is needed.
// Stalls squeeze out bubbles stage by stage; o_in_ready drops only when every stage is full
// and the output transaction is not being taken. o_cfg_ready is always high.

module scalability_threshold_freq_select_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire stfs_pkg::t_core     i_core_index,
    input  wire stfs_pkg::t_cnt_in   i_productive_count,
    input  wire stfs_pkg::t_cnt_in   i_active_count,

    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output stfs_pkg::t_core          o_out_core,
    output stfs_pkg::t_freq          o_freq_request,
    output logic                     o_write_needed,
    output stfs_pkg::t_total         o_request_total,

    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire stfs_pkg::t_cfg_idx  i_cfg_index,
    input  wire stfs_pkg::t_cfg_data i_cfg_data
);

    import stfs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_thr  r_thr_low;
    t_thr  r_thr_high;
    t_freq r_freq_below_low;
    t_freq r_freq_below_high;
    t_freq r_freq_above_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low         <= RST_THRESHOLD_LOW;
            r_thr_high        <= RST_THRESHOLD_HIGH;
            r_freq_below_low  <= RST_FREQ_BELOW_LOW;
            r_freq_below_high <= RST_FREQ_BELOW_HIGH;
            r_freq_above_high <= RST_FREQ_ABOVE_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD_LOW:   r_thr_low         <= i_cfg_data[THR_W-1:0];
                CFG_THRESHOLD_HIGH:  r_thr_high        <= i_cfg_data[THR_W-1:0];
                CFG_FREQ_BELOW_LOW:  r_freq_below_low  <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_BELOW_HIGH: r_freq_below_high <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_ABOVE_HIGH: r_freq_above_high <= i_cfg_data[FREQ_W-1:0];
                default: ;  // ignore writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or draining
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic mv1, mv2, mv3, mv4;
    logic accept, core_ok, take;

    assign rdy5 = !r_out_valid || i_out_ready;
    assign mv4  = r_v4 && rdy5;
    assign rdy4 = !r_v4 || rdy5;
    assign mv3  = r_v3 && rdy4;
    assign rdy3 = !r_v3 || rdy4;
    assign mv2  = r_v2 && rdy3;
    assign rdy2 = !r_v2 || rdy3;
    assign mv1  = r_v1 && rdy2;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_ready = rdy1;
    assign accept     = i_in_valid && rdy1;
    // Drop transactions for cores the block does not track
    assign core_ok    = 32'(i_core_index) < NUM_CORES;
    assign take       = accept && core_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= take;
            if (rdy2) r_v2 <= mv1;
            if (rdy3) r_v3 <= mv2;
            if (rdy4) r_v4 <= mv3;
            if (rdy5) r_out_valid <= mv4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: previous counter readings. Write the new readings at the
    // accepting edge; the read-first RAM hands back the old pair.
    // ------------------------------------------------------------------
    t_core_addr in_addr;
    t_cnt       in_pc;
    t_cnt       in_ac;
    logic [PAIR_W-1:0] prev_pair;

    assign in_addr = i_core_index[CORE_AW-1:0];
    assign in_pc   = i_productive_count[COUNTER_BITS-1:0];
    assign in_ac   = i_active_count[COUNTER_BITS-1:0];

    stfs_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (NUM_CORES)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (take),
        .i_wr_addr (in_addr),
        .i_wr_data ({in_ac, in_pc}),
        .i_rd_en   (take),
        .i_rd_addr (in_addr),
        .o_rd_data (prev_pair)
    );

    logic [NUM_CORES-1:0] r_seen;
    t_core r_s1_core;
    t_cnt  r_s1_pc;
    t_cnt  r_s1_ac;
    logic  r_s1_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (take) begin
            r_seen[in_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_core <= i_core_index;
            r_s1_pc   <= in_pc;
            r_s1_ac   <= in_ac;
            r_s1_seen <= r_seen[in_addr];
        end
    end

    // Modular deltas
    t_cnt s1_dp;
    t_cnt s1_da;

    assign s1_dp = r_s1_pc - prev_pair[COUNTER_BITS-1:0];
    assign s1_da = r_s1_ac - prev_pair[PAIR_W-1:COUNTER_BITS];

    // ------------------------------------------------------------------
    // Stage 2: split dA times each threshold into two partial products
    // ------------------------------------------------------------------
    t_core r_s2_core;
    t_cnt  r_s2_dp;
    t_cnt  r_s2_da;
    logic  r_s2_rv;   // ratio defined: earlier sample exists and dA nonzero

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_s2_core <= r_s1_core;
            r_s2_dp   <= s1_dp;
            r_s2_da   <= s1_da;
            r_s2_rv   <= r_s1_seen && (s1_da != '0);
        end
    end

    t_plo s2_lo_low, s2_lo_high;
    t_phi s2_hi_low, s2_hi_high;

    assign s2_lo_low  = PLO_W'(r_s2_da[LO_W-1:0]) * PLO_W'(r_thr_low);
    assign s2_hi_low  = PHI_W'(r_s2_da[COUNTER_BITS-1:LO_W]) * PHI_W'(r_thr_low);
    assign s2_lo_high = PLO_W'(r_s2_da[LO_W-1:0]) * PLO_W'(r_thr_high);
    assign s2_hi_high = PHI_W'(r_s2_da[COUNTER_BITS-1:LO_W]) * PHI_W'(r_thr_high);

    // ------------------------------------------------------------------
    // Stage 3: sum partial products into full T * dA
    // ------------------------------------------------------------------
    t_core r_s3_core;
    t_cnt  r_s3_dp;
    logic  r_s3_rv;
    t_plo  r_s3_lo_low, r_s3_lo_high;
    t_phi  r_s3_hi_low, r_s3_hi_high;

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_s3_core    <= r_s2_core;
            r_s3_dp      <= r_s2_dp;
            r_s3_rv      <= r_s2_rv;
            r_s3_lo_low  <= s2_lo_low;
            r_s3_hi_low  <= s2_hi_low;
            r_s3_lo_high <= s2_lo_high;
            r_s3_hi_high <= s2_hi_high;
        end
    end

    t_prod s3_prod_low, s3_prod_high;

    assign s3_prod_low  = PROD_W'(r_s3_lo_low)  + (PROD_W'(r_s3_hi_low)  << LO_W);
    assign s3_prod_high = PROD_W'(r_s3_lo_high) + (PROD_W'(r_s3_hi_high) << LO_W);

    // ------------------------------------------------------------------
    // Stage 4: compare, pick frequency, check against last setting
    // ------------------------------------------------------------------
    t_core r_s4_core;
    t_cnt  r_s4_dp;
    logic  r_s4_rv;
    t_prod r_s4_prod_low, r_s4_prod_high;
    logic  r_s4_fwd_hit;
    t_freq r_s4_fwd_val;
    t_freq last_rd;

    logic [NUM_CORES-1:0] r_set_valid;
    t_total r_count;

    t_core_addr s4_addr;
    t_prod      s4_left;
    logic       s4_le_low, s4_le_high;
    t_freq      s4_freq;
    t_freq      s4_last;
    logic       s4_write;
    logic       ls_wr_en;
    t_total     s4_total;

    assign s4_addr    = r_s4_core[CORE_AW-1:0];
    // dP scaled to the threshold's fraction
    assign s4_left    = {1'b0, r_s4_dp, {THRESH_FRAC_BITS{1'b0}}};
    assign s4_le_low  = s4_left <= r_s4_prod_low;
    assign s4_le_high = s4_left <= r_s4_prod_high;

    always_comb begin
        priority if (!r_s4_rv) begin
            s4_freq = r_freq_above_high;
        end else if (s4_le_low) begin
            s4_freq = r_freq_below_low;
        end else if (s4_le_high) begin
            s4_freq = r_freq_below_high;
        end else begin
            s4_freq = r_freq_above_high;
        end
    end

    // Take the value written by the item just ahead when the RAM read raced it
    assign s4_last  = r_s4_fwd_hit ? r_s4_fwd_val : last_rd;
    assign s4_write = !r_set_valid[s4_addr] || (s4_last != s4_freq);
    assign ls_wr_en = mv4 && s4_write;
    assign s4_total = s4_write ? r_count + TOTAL_W'(1) : r_count;

    stfs_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (NUM_CORES)
    ) u_setting_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ls_wr_en),
        .i_wr_addr (s4_addr),
        .i_wr_data (s4_freq),
        .i_rd_en   (mv3),
        .i_rd_addr (r_s3_core[CORE_AW-1:0]),
        .o_rd_data (last_rd)
    );

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_s4_core      <= r_s3_core;
            r_s4_dp        <= r_s3_dp;
            r_s4_rv        <= r_s3_rv;
            r_s4_prod_low  <= s3_prod_low;
            r_s4_prod_high <= s3_prod_high;
            r_s4_fwd_hit   <= ls_wr_en && (r_s4_core == r_s3_core);
            r_s4_fwd_val   <= s4_freq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_valid <= '0;
            r_count     <= '0;
        end else if (ls_wr_en) begin
            r_set_valid[s4_addr] <= 1'b1;
            r_count              <= s4_total;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_core  r_out_core;
    t_freq  r_out_freq;
    logic   r_out_write;
    t_total r_out_total;

    always_ff @(posedge i_clk) begin
        if (mv4) begin
            r_out_core  <= r_s4_core;
            r_out_freq  <= s4_freq;
            r_out_write <= s4_write;
            r_out_total <= s4_total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_core      = r_out_core;
    assign o_freq_request  = r_out_freq;
    assign o_write_needed  = r_out_write;
    assign o_request_total = r_out_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ls_wr_en |=> r_count == $past(r_count))
        else $error("change count moved without a write");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ls_wr_en |=> r_count == TOTAL_W'($past(r_count) + TOTAL_W'(1)))
        else $error("change count did not advance by one on a write");

    a_total_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_total == r_count)
        else $error("pending request total differs from change count");

    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_s4_fwd_hit) |-> r_set_valid[s4_addr])
        else $error("forwarded setting for a core with no setting");

endmodule

`default_nettype wire

@@ sv/stfs_ram.sv @@
`default_nettype none

module stfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read-first: a read and a write to one address at one edge return the old word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ tb/sv/scalability_threshold_freq_select_unit_tb.sv @@
`timescale 1ns / 1ps

import stfs_pkg::*;

// One frequency request as it should leave the block.
typedef struct packed {
    t_core  core;
    t_freq  freq;
    logic   write;
    t_total total;
} t_freq_req;

// Tracks per-core counter history and issued settings, and holds the requests still owed.
class freq_request_tracker;
    t_thr      thr_low;
    t_thr      thr_high;
    t_freq     freq_low;
    t_freq     freq_mid;
    t_freq     freq_high;
    t_cnt      last_prod [NUM_CORES];
    t_cnt      last_act [NUM_CORES];
    bit        seen [NUM_CORES];
    t_freq     issued [NUM_CORES];
    bit        issued_ok [NUM_CORES];
    t_total    changes;
    t_freq_req owed_requests [$];
    int        mismatches;

    function new();
        thr_low    = RST_THRESHOLD_LOW;
        thr_high   = RST_THRESHOLD_HIGH;
        freq_low   = RST_FREQ_BELOW_LOW;
        freq_mid   = RST_FREQ_BELOW_HIGH;
        freq_high  = RST_FREQ_ABOVE_HIGH;
        changes    = '0;
        mismatches = 0;
        foreach (seen[i]) begin
            seen[i]      = 1'b0;
            issued_ok[i] = 1'b0;
        end
    endfunction

    function void apply_config(t_cfg_idx idx, t_cfg_data data);
        case (idx)
            CFG_THRESHOLD_LOW:   thr_low   = t_thr'(data);
            CFG_THRESHOLD_HIGH:  thr_high  = t_thr'(data);
            CFG_FREQ_BELOW_LOW:  freq_low  = data[FREQ_W-1:0];
            CFG_FREQ_BELOW_HIGH: freq_mid  = data[FREQ_W-1:0];
            CFG_FREQ_ABOVE_HIGH: freq_high = data[FREQ_W-1:0];
            default: ;
        endcase
    endfunction

    // dp/da <= thr/2^frac, compared as dp*2^frac <= thr*da at full width
    function bit ratio_at_or_below(t_cnt dp, t_cnt da, t_thr thr);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = {64'b0, dp} << THRESH_FRAC_BITS;
        rhs = {64'b0, da} * {111'b0, thr};
        return lhs <= rhs;
    endfunction

    function void note_sample(t_core core, t_cnt_in prod, t_cnt_in act);
        t_cnt      dp;
        t_cnt      da;
        t_freq     freq;
        bit        write;
        t_freq_req req;
        if (int'(core) >= NUM_CORES) return;
        freq = freq_high;
        if (seen[core]) begin
            dp = t_cnt'(prod) - last_prod[core];
            da = t_cnt'(act) - last_act[core];
            if (da != '0) begin
                if (ratio_at_or_below(dp, da, thr_low))
                    freq = freq_low;
                else if (ratio_at_or_below(dp, da, thr_high))
                    freq = freq_mid;
            end
        end
        last_prod[core] = t_cnt'(prod);
        last_act[core]  = t_cnt'(act);
        seen[core]      = 1'b1;
        write = !issued_ok[core] || issued[core] != freq;
        if (write) begin
            issued[core]    = freq;
            issued_ok[core] = 1'b1;
            changes         = changes + TOTAL_W'(1);
        end
        req.core  = core;
        req.freq  = freq;
        req.write = write;
        req.total = changes;
        owed_requests.insert(owed_requests.size(), req);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_request(t_core core, t_freq freq, logic write, t_total total);
        t_freq_req req;
        if (owed_requests.size() == 0) begin
            $display("%0t: unexpected request: expected none actual core %0d freq %0d",
                     $time, core, freq);
            mismatches++;
            return;
        end
        req = owed_requests.pop_front();
        compare_field("out_core", req.core, core);
        compare_field("freq_request", req.freq, freq);
        compare_field("write_needed", req.write, write);
        compare_field("request_total", req.total, total);
    endfunction
endclass

module scalability_threshold_freq_select_unit_tb;

    localparam int       RESET_CYCLES = 7;
    localparam int       PIPE_LATENCY = 5;
    localparam int       CYCLE_LIMIT  = 1000000;
    localparam t_cfg_idx CFG_UNUSED   = 3'd7;

    logic      i_clk;
    logic      i_rst_n            = 1'b0;
    logic      i_in_valid         = 1'b0;
    logic      o_in_ready;
    t_core     i_core_index       = '0;
    t_cnt_in   i_productive_count = '0;
    t_cnt_in   i_active_count     = '0;
    logic      o_out_valid;
    logic      i_out_ready        = 1'b0;
    t_core     o_out_core;
    t_freq     o_freq_request;
    logic      o_write_needed;
    t_total    o_request_total;
    logic      i_cfg_valid        = 1'b0;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index        = '0;
    t_cfg_data i_cfg_data         = '0;

    freq_request_tracker tracker = new();

    // Stimulus-side view of each core's free-running counters
    t_cnt_in     core_prod_reading [NUM_CORES];
    t_cnt_in     core_act_reading [NUM_CORES];
    int unsigned hot_cores   = 4;
    bit          sender_calm = 1'b0;
    bit          ready_calm  = 1'b0;
    int unsigned ready_left  = 0;
    int unsigned ready_roll;
    int unsigned cycle_count = 0;

    scalability_threshold_freq_select_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a run that hangs on a handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Throttle the result side: hold ready for random stretches, mostly short stalls and
    // now and then a long one; keep it high while the calm flag is set.
    always @(posedge i_clk) begin
        if (ready_left != 0) begin
            ready_left--;
        end else if (ready_calm) begin
            i_out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                i_out_ready <= 1'b1;
                ready_left = $urandom_range(0, 15);
            end else if (ready_roll < 93) begin
                i_out_ready <= 1'b0;
                ready_left = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                ready_left = $urandom_range(10, 50);
            end
        end
    end

    // Check every result transaction against the oldest owed request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_request(o_out_core, o_freq_request, o_write_needed, o_request_total);
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Write one register; leave valid high so back-to-back writes follow without a gap.
    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.apply_config(idx, data);
    endtask

    task automatic program_config(t_thr thr_lo, t_thr thr_hi, t_cfg_data f_lo,
                                  t_cfg_data f_mid, t_cfg_data f_hi);
        write_reg(CFG_THRESHOLD_LOW, t_cfg_data'(thr_lo));
        write_reg(CFG_THRESHOLD_HIGH, t_cfg_data'(thr_hi));
        write_reg(CFG_FREQ_BELOW_LOW, f_lo);
        write_reg(CFG_FREQ_BELOW_HIGH, f_mid);
        write_reg(CFG_FREQ_ABOVE_HIGH, f_hi);
        i_cfg_valid <= 1'b0;
    endtask

    // Present one sample transaction; drop valid only for an idle gap before it.
    task automatic send_sample(t_core core, t_cnt_in prod, t_cnt_in act);
        int unsigned gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_core_index       <= core;
        i_productive_count <= prod;
        i_active_count     <= act;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_sample(core, prod, act);
    endtask

    task automatic sample_at(t_core core, t_cnt_in prod, t_cnt_in act);
        core_prod_reading[core] = prod;
        core_act_reading[core]  = act;
        send_sample(core, prod, act);
    endtask

    // Advance a core's counters by the given deltas; the sum wraps like the hardware counters.
    task automatic advance(t_core core, t_cnt_in dp, t_cnt_in da);
        sample_at(core, core_prod_reading[core] + dp, core_act_reading[core] + da);
    endtask

    // Mostly well-formed advances, most with a ratio near a threshold; the rest undefined
    // ratios and raw noise.
    task automatic random_sample();
        t_core        core;
        t_cnt_in      dp;
        t_cnt_in      da;
        logic [127:0] scaled;
        int           ratio;
        int unsigned  roll;
        roll = $urandom_range(0, 9);
        core = (roll < 8) ? t_core'($urandom_range(0, hot_cores - 1)) : t_core'($urandom);
        case ($urandom_range(0, 3))
            0: da = t_cnt_in'($urandom_range(0, 1000));
            1: da = t_cnt_in'($urandom);
            2: da = {$urandom, $urandom};
            default: da = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        case ($urandom_range(0, 4))
            0, 1: ratio = int'(tracker.thr_low) + int'($urandom_range(0, 64)) - 32;
            2, 3: ratio = int'(tracker.thr_high) + int'($urandom_range(0, 64)) - 32;
            default: ratio = int'($urandom_range(0, 262143));
        endcase
        if (ratio < 0) ratio = 0;
        scaled = ({64'b0, da} * 128'(ratio)) >> THRESH_FRAC_BITS;
        dp = scaled[63:0] + t_cnt_in'($urandom_range(0, 2)) - 64'd1;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            da = '0;
        end else if (roll >= 90) begin
            dp = {$urandom, $urandom};
            da = {$urandom, $urandom};
        end
        advance(core, dp, da);
    endtask

    // Run the random part of a phase, then hold until every owed request is back and
    // the pipe has had time to empty.
    task automatic run_random(int count);
        repeat (count) random_sample();
        i_in_valid <= 1'b0;
        while (tracker.owed_requests.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
    endtask

    initial begin
        foreach (core_prod_reading[i]) begin
            core_prod_reading[i] = '0;
            core_act_reading[i]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: first sample, ratio exactly at the lower threshold, frozen active
        // count, all-ones readings and a wrap of both counters.
        hot_cores = 4;
        sample_at(t_core'(0), '0, '0);
        advance(t_core'(0), 64'd100, 64'd200);
        advance(t_core'(0), 64'd100, 64'd0);
        sample_at(t_core'(63), '1, '1);
        sample_at(t_core'(63), 64'd5, 64'd9);
        run_random(150);

        // Distinct frequencies: both thresholds hit exactly and the upper one just missed, a zero
        // productive delta, largest productive delta, ratio of one.
        hot_cores = 8;
        program_config(17'd32768, 17'd45875, 17'd1200, 17'd2400, 17'd3600);
        sample_at(t_core'(1), '1, '0);
        advance(t_core'(1), 64'd45875, 64'd65536);
        advance(t_core'(1), 64'd45876, 64'd65536);
        advance(t_core'(1), 64'd32768, 64'd65536);
        advance(t_core'(1), 64'd0, 64'd65536);
        advance(t_core'(1), '1, 64'd1);
        sample_at(t_core'(2), '0, '0);
        advance(t_core'(2), '1, '1);
        run_random(250);

        // Extreme thresholds and frequencies; a write to an unused index must change nothing.
        hot_cores = 64;
        write_reg(CFG_UNUSED, '1);
        program_config(17'd0, 17'd131071, 17'd0, 17'd65535, 17'd1);
        advance(t_core'(1), 64'd0, 64'd5);
        advance(t_core'(1), 64'd1, '1);
        advance(t_core'(1), 64'd131071, 64'd65536);
        advance(t_core'(1), 64'd131072, 64'd65536);
        run_random(200);

        // Thresholds in reverse order: the low-threshold register is still tested first.
        hot_cores = 2;
        program_config(17'd45875, 17'd32768, 17'h1FFFF, 17'd0, 17'd7);
        advance(t_core'(1), 64'd6, 64'd10);
        advance(t_core'(1), 64'd8, 64'd10);
        advance(t_core'(1), 64'd4, 64'd10);
        run_random(200);

        // Random settings with no idling on either side.
        hot_cores   = 16;
        sender_calm = 1'b1;
        ready_calm  = 1'b1;
        program_config(t_thr'($urandom_range(0, 131071)), t_thr'($urandom_range(0, 131071)),
                       t_cfg_data'($urandom), t_cfg_data'($urandom), t_cfg_data'($urandom));
        run_random(250);

        // Random thresholds with the two lower frequencies equal.
        hot_cores   = 64;
        sender_calm = 1'b0;
        ready_calm  = 1'b0;
        begin
            t_cfg_data shared_freq;
            shared_freq = t_cfg_data'($urandom_range(0, 65535));
            program_config(t_thr'($urandom_range(0, 131071)),
                           t_thr'($urandom_range(0, 131071)),
                           shared_freq, shared_freq, t_cfg_data'($urandom_range(0, 65535)));
        end
        run_random(200);

        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
